// ===== sv/cfcp_pkg.sv =====
// shared types and constants for the crc8 checked command frame parser
// no dependencies; imported by every module of the block
package cfcp_pkg;

	localparam int ByteW  = 8;
	localparam int ValueW = 32;
	localparam int CfgIdxW = 2;

	localparam logic [ByteW-1:0] SignChar = 8'h2D;
	localparam logic [ByteW-1:0] ZeroChar = 8'h30;

	localparam logic [ByteW-1:0] PolyReset   = 8'h07;
	localparam logic [ByteW-1:0] FirstReset  = 8'h41;
	localparam logic [ByteW-1:0] SecondReset = 8'h42;

	// configuration register indexes
	typedef enum logic [CfgIdxW-1:0] {
		CFG_POLY   = 2'd0,
		CFG_FIRST  = 2'd1,
		CFG_SECOND = 2'd2
	} cfg_index_t;

	typedef enum logic [2:0] {
		ST_FIRST_CMD  = 3'd0,
		ST_SECOND_CMD = 3'd1,
		ST_UNKNOWN    = 3'd2,
		ST_TOO_SHORT  = 3'd3,
		ST_CRC_BAD    = 3'd4
	} status_t;

	typedef struct packed {
		logic [ByteW-1:0] poly;
		logic [ByteW-1:0] first_code;
		logic [ByteW-1:0] second_code;
	} cfg_t;

	typedef struct packed {
		status_t           status;
		logic [ByteW-1:0]  command;
		logic [ValueW-1:0] value;
		logic              overflow;
	} result_t;

endpackage

// ===== sv/cfcp_crc8.sv =====
// one byte step of an msb-first crc-8 with a programmable polynomial
// depends on cfcp_pkg
module cfcp_crc8 (
	input  logic [cfcp_pkg::ByteW-1:0] crc,
	input  logic [cfcp_pkg::ByteW-1:0] data,
	input  logic [cfcp_pkg::ByteW-1:0] poly,
	output logic [cfcp_pkg::ByteW-1:0] crc_next
);
	import cfcp_pkg::*;

	always_comb begin
		logic [ByteW-1:0] c;
		c = crc ^ data;
		for (int k = 0; k < ByteW; k++) begin
			if (c[ByteW-1]) begin
				c = {c[ByteW-2:0], 1'b0} ^ poly;
			end else begin
				c = {c[ByteW-2:0], 1'b0};
			end
		end
		crc_next = c;
	end

endmodule

// ===== sv/cfcp_frame.sv =====
// frame state: running crc, decimal accumulator, byte count, command, flags
// builds the result word for the final byte; depends on cfcp_pkg and cfcp_crc8
module cfcp_frame (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       accept,
	input  logic [cfcp_pkg::ByteW-1:0] frame_byte,
	input  logic                       is_last,
	input  cfcp_pkg::cfg_t             cfg,
	output cfcp_pkg::result_t          result
);
	import cfcp_pkg::*;

	localparam int ExactW = ValueW + 4;

	logic [ByteW-1:0]  crc_q;
	logic [ValueW-1:0] acc_q;
	logic [1:0]        seen_q;
	logic [ByteW-1:0]  command_q;
	logic              neg_q;
	logic              ovf_q;

	logic [ByteW-1:0]  crc_next;
	logic [ValueW-1:0] acc_next;
	logic [ExactW-1:0] acc_wide;
	logic [ExactW-1:0] exact;
	logic [ByteW:0]    digit;
	logic              ovf_step;

	cfcp_crc8 u_crc (
		.crc      (crc_q),
		.data     (frame_byte),
		.poly     (cfg.poly),
		.crc_next (crc_next)
	);

	// byte minus '0' as a signed 9 bit value
	assign digit    = {1'b0, frame_byte} - {1'b0, ZeroChar};
	assign acc_next = (acc_q << 3) + (acc_q << 1) + ValueW'(digit[ByteW-1:0])
		- ValueW'({digit[ByteW], 8'h00});
	assign acc_wide = {{(ExactW-ValueW){acc_q[ValueW-1]}}, acc_q};
	assign exact    = (acc_wide << 3) + (acc_wide << 1)
		+ {{(ExactW-ByteW-1){digit[ByteW]}}, digit};
	// exact value leaves the signed 32 bit range when the top bits disagree
	assign ovf_step = !((&exact[ExactW-1:ValueW-1]) || !(|exact[ExactW-1:ValueW-1]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q     <= '0;
			acc_q     <= '0;
			seen_q    <= '0;
			command_q <= '0;
			neg_q     <= 1'b0;
			ovf_q     <= 1'b0;
		end else if (accept) begin
			if (is_last) begin
				crc_q     <= '0;
				acc_q     <= '0;
				seen_q    <= '0;
				command_q <= '0;
				neg_q     <= 1'b0;
				ovf_q     <= 1'b0;
			end else begin
				if (seen_q == 2'd0) begin
					command_q <= frame_byte;
				end else if (seen_q == 2'd1 && frame_byte == SignChar) begin
					neg_q <= 1'b1;
				end else begin
					acc_q <= acc_next;
					ovf_q <= ovf_q | ovf_step;
				end
				crc_q <= crc_next;
				if (seen_q != 2'd3) begin
					seen_q <= seen_q + 2'd1;
				end
			end
		end
	end

	always_comb begin
		result.command  = command_q;
		result.value    = '0;
		result.overflow = 1'b0;
		if (seen_q < 2'd2) begin
			result.status = ST_TOO_SHORT;
		end else if (crc_q != frame_byte) begin
			result.status = ST_CRC_BAD;
		end else begin
			if (command_q == cfg.first_code) begin
				result.status = ST_FIRST_CMD;
			end else if (command_q == cfg.second_code) begin
				result.status = ST_SECOND_CMD;
			end else begin
				result.status = ST_UNKNOWN;
			end
			result.value    = neg_q ? (ValueW'(0) - acc_q) : acc_q;
			result.overflow = ovf_q;
		end
	end

endmodule

// ===== sv/crc8_checked_command_frame_parser.sv =====
// crc8 checked command frame parser, top level
// a result word is registered and valid in the cycle after its final byte is accepted
// throughput: one byte per cycle while frame_ready is high, set by the combinational crc and x10 accumulate step
// the result register stalls input only while it holds a word that is not taken
// arst_n clears frame state, result valid and restores the register defaults
module crc8_checked_command_frame_parser (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        frame_valid,
	output logic                        frame_ready,
	input  logic [cfcp_pkg::ByteW-1:0]  frame_byte,
	input  logic                        is_last,
	output logic                        result_valid,
	input  logic                        result_ready,
	output logic [2:0]                  status,
	output logic [cfcp_pkg::ByteW-1:0]  command_byte,
	output logic signed [cfcp_pkg::ValueW-1:0] payload_value,
	output logic                        payload_overflow,
	input  logic                        cfg_write,
	input  logic [cfcp_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [cfcp_pkg::ByteW-1:0]  cfg_data
);
	import cfcp_pkg::*;

	cfg_t    cfg_q;
	result_t result;
	result_t result_q;
	logic    valid_q;
	logic    accept;

	assign frame_ready = !valid_q || result_ready;
	assign accept      = frame_valid && frame_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.poly        <= PolyReset;
			cfg_q.first_code  <= FirstReset;
			cfg_q.second_code <= SecondReset;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_POLY:   cfg_q.poly        <= cfg_data;
				CFG_FIRST:  cfg_q.first_code  <= cfg_data;
				CFG_SECOND: cfg_q.second_code <= cfg_data;
				default: ;
			endcase
		end
	end

	cfcp_frame u_frame (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.frame_byte (frame_byte),
		.is_last    (is_last),
		.cfg        (cfg_q),
		.result     (result)
	);

	// result register, loaded by the final byte of a frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (accept && is_last) begin
			valid_q <= 1'b1;
		end else if (result_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_last) begin
			result_q <= result;
		end
	end

	assign result_valid     = valid_q;
	assign status           = result_q.status;
	assign command_byte     = result_q.command;
	assign payload_value    = result_q.value;
	assign payload_overflow = result_q.overflow;

endmodule
